>>> sv/lfm_pkg.sv
// Shared types, codes and the fixed state table of the line-follow motor controller.
// Used by lfm_step and line_follow_motor_fsm; depends on nothing else.
package lfm_pkg;

    localparam int STATE_W = 4;
    localparam int COUNT_W = 10;
    localparam int DUTY_W  = 13;
    localparam int DIR_W   = 2;
    localparam int DWELL_W = 10;
    localparam int CODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [STATE_W-1:0] ST_CENTER     = 4'd0;
    localparam logic [STATE_W-1:0] ST_RECOV_R    = 4'd9;
    localparam logic [STATE_W-1:0] ST_RECOV_L    = 4'd10;
    localparam logic [STATE_W-1:0] ST_SHORT_STOP = 4'd12;
    localparam logic [STATE_W-1:0] ST_STOP       = 4'd13;
    localparam logic [STATE_W-1:0] ST_LAST       = 4'd13;

    localparam logic [COUNT_W-1:0] RIGHT_LIMIT_RESET = 10'd600;
    localparam logic [COUNT_W-1:0] LEFT_LIMIT_RESET  = 10'd900;

    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIMIT  = 2'd1;

    typedef enum logic [1:0] {
        REQ_STEP       = 2'd0,
        REQ_STOP       = 2'd1,
        REQ_SHORT_STOP = 2'd2,
        REQ_UNUSED     = 2'd3
    } req_type_t;

    typedef logic [3:0][STATE_W-1:0] next_row_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_right;
        logic [DUTY_W-1:0]  duty_left;
        logic [DIR_W-1:0]   drive_dir;
        logic [DWELL_W-1:0] dwell_ms;
        logic               recov;
        next_row_t          next;
    } row_t;

    typedef struct packed {
        logic [STATE_W-1:0] new_state;
        logic [DIR_W-1:0]   drive_dir;
        logic [DUTY_W-1:0]  duty_right;
        logic [DUTY_W-1:0]  duty_left;
        logic [DWELL_W-1:0] dwell_ms;
    } result_t;

    typedef struct packed {
        logic               emit;
        logic [STATE_W-1:0] state;
        logic [COUNT_W-1:0] count;
        result_t            res;
    } step_out_t;

    // Next-state columns listed in sensor code order, code 0 first.
    function automatic next_row_t nx(input logic [STATE_W-1:0] n0, input logic [STATE_W-1:0] n1,
                                     input logic [STATE_W-1:0] n2,
                                     input logic [STATE_W-1:0] n3);
        return {n3, n2, n1, n0};
    endfunction

    // Codes above the last state read as the center state.
    function automatic row_t lfm_row(input logic [STATE_W-1:0] st);
        row_t r;
        unique case (st)
            4'd1:    r = '{13'd4750, 13'd6750, 2'd2, 10'd50,  1'b0, nx(4'd5, 4'd2, 4'd3, 4'd0)};
            4'd2:    r = '{13'd1500, 13'd1500, 2'd1, 10'd10,  1'b0, nx(4'd5, 4'd1, 4'd3, 4'd0)};
            4'd3:    r = '{13'd4750, 13'd6750, 2'd3, 10'd50,  1'b0, nx(4'd6, 4'd1, 4'd4, 4'd0)};
            4'd4:    r = '{13'd1500, 13'd1500, 2'd1, 10'd10,  1'b0, nx(4'd6, 4'd1, 4'd3, 4'd0)};
            4'd5:    r = '{13'd5000, 13'd7500, 2'd2, 10'd10,  1'b0, nx(4'd7, 4'd7, 4'd7, 4'd7)};
            4'd6:    r = '{13'd7500, 13'd5000, 2'd3, 10'd10,  1'b0, nx(4'd8, 4'd8, 4'd8, 4'd8)};
            4'd7:    r = '{13'd3500, 13'd2000, 2'd1, 10'd10,  1'b0, nx(4'd9, 4'd1, 4'd3, 4'd0)};
            4'd8:    r = '{13'd2000, 13'd3500, 2'd1, 10'd10,  1'b0, nx(4'd9, 4'd1, 4'd3, 4'd0)};
            4'd9:    r = '{13'd0,    13'd2000, 2'd1, 10'd5,   1'b1, nx(4'd9, 4'd1, 4'd3, 4'd0)};
            4'd10:   r = '{13'd2000, 13'd0,    2'd1, 10'd5,   1'b1,
                           nx(4'd10, 4'd1, 4'd3, 4'd0)};
            4'd11:   r = '{13'd3000, 13'd3000, 2'd2, 10'd650, 1'b0, nx(4'd0, 4'd0, 4'd0, 4'd0)};
            4'd12:   r = '{13'd0,    13'd0,    2'd1, 10'd10,  1'b0,
                           nx(4'd11, 4'd11, 4'd11, 4'd11)};
            4'd13:   r = '{13'd0,    13'd0,    2'd1, 10'd100, 1'b0,
                           nx(4'd13, 4'd13, 4'd13, 4'd13)};
            default: r = '{13'd3000, 13'd3000, 2'd1, 10'd15,  1'b0, nx(4'd3, 4'd1, 4'd3, 4'd0)};
        endcase
        return r;
    endfunction

endpackage

>>> sv/lfm_step.sv
// Transition logic of the line-follow motor controller: table lookup, recovery
// counter and timeout override for one request. Depends on lfm_pkg.
module lfm_step
    import lfm_pkg::*;
(
    input  req_type_t          req,
    input  logic [CODE_W-1:0]  sensor_code,
    input  logic [STATE_W-1:0] cur_state,
    input  logic [COUNT_W-1:0] cur_count,
    input  logic [COUNT_W-1:0] right_limit,
    input  logic [COUNT_W-1:0] left_limit,
    output step_out_t          step
);

    row_t               cur_row;
    row_t               ent_row;
    logic [STATE_W-1:0] entered;
    logic [COUNT_W-1:0] bumped;

    assign cur_row = lfm_row(cur_state);
    assign entered = cur_row.next[sensor_code];
    assign ent_row = lfm_row(entered);
    assign bumped  = ent_row.recov ? cur_count + 1'b1 : '0;

    always_comb begin
        step = '0;
        step.state = cur_state;
        step.count = cur_count;
        step.res.drive_dir  = ent_row.drive_dir;
        step.res.duty_right = ent_row.duty_right;
        step.res.duty_left  = ent_row.duty_left;
        step.res.dwell_ms   = ent_row.dwell_ms;
        unique case (req)
            REQ_STEP: begin
                step.emit  = 1'b1;
                step.state = entered;
                step.count = bumped;
                // The timeout swaps the state but the motor fields stay those
                // of the table state that was entered.
                if (entered == ST_RECOV_R && bumped == right_limit) begin
                    step.count = '0;
                    step.state = ST_RECOV_L;
                end else if (entered == ST_RECOV_L && bumped == left_limit) begin
                    step.count = '0;
                    step.state = ST_STOP;
                end
            end
            REQ_STOP:       step.state = ST_STOP;
            REQ_SHORT_STOP: step.state = ST_SHORT_STOP;
            REQ_UNUSED:     step.state = cur_state;
        endcase
        step.res.new_state = step.state;
    end

endmodule

>>> sv/line_follow_motor_fsm.sv
// Top level of the line-follow motor controller: input register, state and limit
// registers, result register. Depends on lfm_pkg and lfm_step.
//
// Usage. Requests arrive as beats on the s_ channel: s_tuser carries the
// request type and s_tdata the two-bit sensor code. A sensor step produces
// one result beat on the m_ channel with the new state and the motor command
// (direction, right and left duty, dwell in milliseconds) of the entered
// table state. Force-stop and short-stop requests, and the unused request
// code, change the state as required and produce no result beat.
// The cfg channel writes the two recovery limits (index 0 right, index 1
// left); it is always ready and should only be used while the block is idle.
// A step accepted into the input register passes through the transition logic into the
// result register, from which the receiver takes it on m_.
// Throughput: one request per cycle while the receiver takes the results, set by the loop
// through the state register, the table lookup and the recovery counter compare.
// Reset (aresetn low, synchronous) returns to the center state, clears the
// recovery count, restores the limits to 600 and 900 and empties both the
// input and the result registers.
// When the receiver stalls, the result register holds its beat and the input
// register keeps one more request, after which s_tready drops; force requests
// still drain from the input register since they produce no result.
module line_follow_motor_fsm
    import lfm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [1:0] sensor_code, [7:2] zero
    input  logic [1:0]           s_tuser,   // [1:0] req_type
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // [3:0] new_state, [5:4] drive_dir,
                                            // [18:6] duty_right, [31:19] duty_left,
                                            // [41:32] dwell_ms, [47:42] zero
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data
);

    // Input register: one request waiting for the transition logic.
    logic               in_valid_reg, in_valid_next;
    req_type_t          in_req_reg;
    logic [CODE_W-1:0]  in_code_reg;

    // Machine state and configuration.
    logic [STATE_W-1:0] state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] right_limit_reg, right_limit_next;
    logic [COUNT_W-1:0] left_limit_reg, left_limit_next;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg;

    step_out_t          step;
    logic               out_free;
    logic               proc_fire;

    lfm_step u_step (
        .req         (in_req_reg),
        .sensor_code (in_code_reg),
        .cur_state   (state_reg),
        .cur_count   (count_reg),
        .right_limit (right_limit_reg),
        .left_limit  (left_limit_reg),
        .step        (step)
    );

    // The result slot is free when empty or being emptied on this edge. A
    // request with no result never waits on it.
    assign out_free  = !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && (!step.emit || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next    = in_valid_reg;
        state_next       = state_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        right_limit_next = right_limit_reg;
        left_limit_next  = left_limit_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (proc_fire) begin
            state_next    = step.state;
            count_next    = step.count;
            in_valid_next = 1'b0;
            if (step.emit) begin
                out_valid_next = 1'b1;
            end
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end

        // Indexes beyond the two limits are accepted and dropped.
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_RIGHT_LIMIT) begin
                right_limit_next = cfg_data;
            end else if (cfg_index == CFG_LEFT_LIMIT) begin
                left_limit_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= ST_CENTER;
            count_reg       <= '0;
            right_limit_reg <= RIGHT_LIMIT_RESET;
            left_limit_reg  <= LEFT_LIMIT_RESET;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            state_reg       <= state_next;
            count_reg       <= count_next;
            right_limit_reg <= right_limit_next;
            left_limit_reg  <= left_limit_next;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg  <= req_type_t'(s_tuser);
            in_code_reg <= s_tdata[CODE_W-1:0];
        end
        if (proc_fire && step.emit) begin
            out_res_reg <= step.res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.dwell_ms, out_res_reg.duty_left,
                       out_res_reg.duty_right, out_res_reg.drive_dir, out_res_reg.new_state};

    // The machine never leaves the fourteen table states.
    a_state_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg <= ST_LAST)
        else $error("state register outside the table");

    // A delivered beat reports the state the machine now holds, unless a
    // later request has already moved it.
    a_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && step.emit |=> m_tvalid && out_res_reg.new_state == state_reg)
        else $error("result beat does not match the new state");

    // A force-stop request lands in the stop state and emits nothing.
    a_force_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_req_reg == REQ_STOP |=> state_reg == ST_STOP
            && $stable(count_reg))
        else $error("force stop did not reach the stop state");

    // A step never overwrites a result beat that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && step.emit |-> !out_valid_reg || m_tready)
        else $error("result beat overwritten while stalled");

endmodule

>>> verif/lfm_motor_checker.sv
// Scoreboard for the line-follow motor controller: watches the request, result and
// limit-write channels, predicts each motor command and compares it with the result beats.
// Depends on lfm_pkg for widths, state codes, request codes and register indexes.
module lfm_motor_checker
    import lfm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   cmds_checked,
    output int                   right_timeouts,
    output int                   left_timeouts
);

    localparam logic [DIR_W-1:0] DIR_FWD    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_SPIN_R = 2'd2;
    localparam logic [DIR_W-1:0] DIR_SPIN_L = 2'd3;

    // Successor states hold one nibble per sensor code, code 0 in the lowest nibble.
    typedef struct packed {
        logic [DUTY_W-1:0]  duty_r;
        logic [DUTY_W-1:0]  duty_l;
        logic [DIR_W-1:0]   dir;
        logic [DWELL_W-1:0] dwell;
        logic               recov;
        logic [15:0]        succ;
    } motor_row_t;

    result_t                expected_cmds[$];
    logic [STATE_W-1:0]     motor_state;
    logic [COUNT_W-1:0]     turn_ticks;
    logic [COUNT_W-1:0]     right_limit;
    logic [COUNT_W-1:0]     left_limit;
    int                     fails;
    int                     reported;
    int                     checked;
    int                     right_hits;
    int                     left_hits;

    function automatic motor_row_t motor_row(input logic [STATE_W-1:0] st);
        case (st)
            4'd1:    return '{13'd4750, 13'd6750, DIR_SPIN_R, 10'd50,  1'b0, 16'h0325};
            4'd2:    return '{13'd1500, 13'd1500, DIR_FWD,    10'd10,  1'b0, 16'h0315};
            4'd3:    return '{13'd4750, 13'd6750, DIR_SPIN_L, 10'd50,  1'b0, 16'h0416};
            4'd4:    return '{13'd1500, 13'd1500, DIR_FWD,    10'd10,  1'b0, 16'h0316};
            4'd5:    return '{13'd5000, 13'd7500, DIR_SPIN_R, 10'd10,  1'b0, 16'h7777};
            4'd6:    return '{13'd7500, 13'd5000, DIR_SPIN_L, 10'd10,  1'b0, 16'h8888};
            4'd7:    return '{13'd3500, 13'd2000, DIR_FWD,    10'd10,  1'b0, 16'h0319};
            4'd8:    return '{13'd2000, 13'd3500, DIR_FWD,    10'd10,  1'b0, 16'h0319};
            4'd9:    return '{13'd0,    13'd2000, DIR_FWD,    10'd5,   1'b1, 16'h0319};
            4'd10:   return '{13'd2000, 13'd0,    DIR_FWD,    10'd5,   1'b1, 16'h031A};
            4'd11:   return '{13'd3000, 13'd3000, DIR_SPIN_R, 10'd650, 1'b0, 16'h0000};
            4'd12:   return '{13'd0,    13'd0,    DIR_FWD,    10'd10,  1'b0, 16'hBBBB};
            4'd13:   return '{13'd0,    13'd0,    DIR_FWD,    10'd100, 1'b0, 16'hDDDD};
            default: return '{13'd3000, 13'd3000, DIR_FWD,    10'd15,  1'b0, 16'h0313};
        endcase
    endfunction

    // Moves the machine by one request and queues the motor command a sensor step gives.
    task automatic advance_motor_state(input req_type_t req, input logic [1:0] code);
        logic [STATE_W-1:0] from;
        logic [STATE_W-1:0] entered;
        logic [STATE_W-1:0] landed;
        motor_row_t         row;
        result_t            cmd;
        case (req)
            REQ_STOP:       motor_state = ST_STOP;
            REQ_SHORT_STOP: motor_state = ST_SHORT_STOP;
            REQ_STEP: begin
                from    = (motor_state > ST_LAST) ? ST_CENTER : motor_state;
                row     = motor_row(from);
                entered = row.succ[code*STATE_W +: STATE_W];
                row     = motor_row(entered);
                landed  = entered;
                turn_ticks = row.recov ? turn_ticks + 1'b1 : '0;
                if (entered == ST_RECOV_R && turn_ticks == right_limit) begin
                    turn_ticks = '0;
                    landed     = ST_RECOV_L;
                    right_hits++;
                end else if (entered == ST_RECOV_L && turn_ticks == left_limit) begin
                    turn_ticks = '0;
                    landed     = ST_STOP;
                    left_hits++;
                end
                motor_state = landed;
                // Motor fields come from the table state entered, not the override.
                cmd.new_state  = landed;
                cmd.drive_dir  = row.dir;
                cmd.duty_right = row.duty_r;
                cmd.duty_left  = row.duty_l;
                cmd.dwell_ms   = row.dwell;
                expected_cmds.push_back(cmd);
            end
            default: ;
        endcase
    endtask

    task automatic check_motor_cmd(input logic [47:0] beat);
        result_t cmd;
        if (expected_cmds.size() == 0) begin
            fails++;
            if (reported < 10) begin
                reported++;
                $display("result beat %h arrived with no command outstanding", beat);
            end
        end else begin
            cmd = expected_cmds.pop_front();
            checked++;
            if (beat[3:0] !== cmd.new_state || beat[5:4] !== cmd.drive_dir ||
                beat[18:6] !== cmd.duty_right || beat[31:19] !== cmd.duty_left ||
                beat[41:32] !== cmd.dwell_ms || beat[47:42] !== '0) begin
                fails++;
                if (reported < 10) begin
                    reported++;
                    $display("result %0d: expected state %0d dir %0d right %0d left %0d dwell %0d",
                             checked, cmd.new_state, cmd.drive_dir, cmd.duty_right,
                             cmd.duty_left, cmd.dwell_ms);
                    $display("            got state %0d dir %0d right %0d left %0d dwell %0d pad %h",
                             beat[3:0], beat[5:4], beat[18:6], beat[31:19], beat[41:32],
                             beat[47:42]);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_cmds.delete();
            motor_state = ST_CENTER;
            turn_ticks  = '0;
            right_limit = RIGHT_LIMIT_RESET;
            left_limit  = LEFT_LIMIT_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RIGHT_LIMIT) begin
                    right_limit = cfg_data;
                end else if (cfg_index == CFG_LEFT_LIMIT) begin
                    left_limit = cfg_data;
                end
            end
            if (m_tvalid && m_tready) begin
                check_motor_cmd(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                advance_motor_state(req_type_t'(s_tuser), s_tdata[1:0]);
            end
        end
        fail_count     <= fails;
        pending        <= expected_cmds.size();
        cmds_checked   <= checked;
        right_timeouts <= right_hits;
        left_timeouts  <= left_hits;
    end

endmodule

>>> verif/tb.sv
// Testbench top for line_follow_motor_fsm: clock, reset, request and limit stimulus,
// result-side back-pressure, watchdog and verdict. Depends on lfm_pkg and lfm_motor_checker.
module tb
    import lfm_pkg::*;
();

    // Nothing moving on any channel up to the watchdog limit means the block is stuck. The
    // long receiver hold-off is well below this limit.
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    // A step's result passes through the input and result registers; force requests leave no
    // trace on the result side, so the settle wait lets them drain before any limit write.
    localparam int SETTLE_CYCLES = 4;

    // Indexes with no register behind them; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_data  = '0;

    int fail_count;
    int pending;
    int cmds_checked;
    int right_timeouts;
    int left_timeouts;

    // Stimulus bookkeeping: beats that the block acts on, the current burst, the limits.
    int                 beats_sent;
    int                 burst_left;
    int                 settings_used;
    logic [COUNT_W-1:0] cur_right = RIGHT_LIMIT_RESET;
    logic [COUNT_W-1:0] cur_left  = LEFT_LIMIT_RESET;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    line_follow_motor_fsm i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lfm_motor_checker i_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .cmds_checked   (cmds_checked),
        .right_timeouts (right_timeouts),
        .left_timeouts  (left_timeouts)
    );

    // Offers one request beat and returns at the edge where it is taken. Beats come in
    // bursts of random length; before a burst the sender may go quiet for a while, now and
    // then for a long stretch, so gaps land on every phase of the block's pipeline.
    task automatic send_beat(input req_type_t req, input logic [1:0] code);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) begin
                gap = $urandom_range(10, 30);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'b0, code};
        do @(posedge aclk); while (!s_tready);
        if (req != REQ_UNUSED) begin
            beats_sent++;
        end
    endtask

    task automatic step(input logic [1:0] code);
        send_beat(REQ_STEP, code);
    endtask

    // Drops valid, lets the last accepted beat reach the scoreboard, then waits until every
    // predicted result has come back and any force request has drained through the pipe.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // New limits go in only once the block is idle. A write to a spare index rides along
    // each time; it must leave both limits alone.
    task automatic set_limits(input logic [COUNT_W-1:0] right, input logic [COUNT_W-1:0] left);
        wait_idle();
        write_reg(CFG_RIGHT_LIMIT, right);
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                  COUNT_W'($urandom_range(0, 1023)));
        write_reg(CFG_LEFT_LIMIT, left);
        cfg_valid <= 1'b0;
        cur_right = right;
        cur_left  = left;
        settings_used++;
    endtask

    // One way into the recovery turns: short stop, then through state 11 back to
    // center, out to the right, through the spin and the veer into the right recovery
    // turn. From there code 0 keeps the machine turning; a stray code leaves the turn.
    task automatic run_recovery(input int len, input int stray_pct);
        send_beat(REQ_SHORT_STOP, 2'($urandom_range(0, 3)));
        step(2'($urandom_range(0, 3)));
        step(2'($urandom_range(0, 3)));
        step(2'd1);
        step(2'd0);
        step(2'($urandom_range(0, 3)));
        step(2'd0);
        repeat (len) begin
            step(($urandom_range(0, 99) < stray_pct) ? 2'($urandom_range(1, 3)) : 2'd0);
        end
    endtask

    // Mostly recovery runs sized from the current limits, capped at 60 steps, so both timeouts
    // fire under small limits, plus random walks through the table and the ignored request code.
    task automatic random_phase(input int n_beats);
        int target;
        int span;
        target = beats_sent + n_beats;
        span = int'(cur_right) + int'(cur_left) + 3;
        if (span > 60) begin
            span = 60;
        end
        while (beats_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: run_recovery($urandom_range(1, span), 8);
                6, 7, 8: repeat ($urandom_range(1, 10)) step(2'($urandom_range(0, 3)));
                default: send_beat(req_type_t'($urandom_range(0, 3)),
                                   2'($urandom_range(0, 3)));
            endcase
        end
    endtask

    // Receiver: stalls on patterns drawn at random, from always ready to one beat in four. Twice,
    // after a set number of results, it holds off for a long stretch while the sender keeps
    // offering steps, so the result register and the input register fill and s_tready has to drop.
    initial begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       tick;
        int       got;
        int       holds;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        got       = 0;
        holds     = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got++;
            end
            if (holds < 2 && got >= ((holds == 0) ? 40 : 700)) begin
                holds++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                tick++;
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("watchdog: no beat on any channel for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        beats_sent    = 0;
        burst_left    = 0;
        settings_used = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk under the reset limits. It visits every table state but the left
        // recovery turn, hits the full 7500 duty, the 650 ms and 5 ms dwells, both force
        // requests, the ignored request code, the stop state holding under steps, and a
        // short stay in the right recovery turn that a stray code then leaves.
        step(2'd0);
        step(2'd2);
        step(2'd0);
        step(2'd3);
        step(2'd1);
        step(2'd1);
        step(2'd0);
        step(2'd2);
        step(2'd3);
        send_beat(REQ_UNUSED, 2'd3);
        send_beat(REQ_SHORT_STOP, 2'd0);
        step(2'd3);
        step(2'd0);
        send_beat(REQ_STOP, 2'd2);
        step(2'd3);
        step(2'd1);
        send_beat(REQ_SHORT_STOP, 2'd1);
        step(2'd2);
        step(2'd1);
        step(2'd1);
        step(2'd0);
        step(2'd1);
        step(2'd0);
        step(2'd0);
        step(2'd3);

        random_phase(80);
        set_limits(10'd1, 10'd1);
        random_phase(30);
        set_limits(10'd3, 10'd1023);
        random_phase(30);
        set_limits(COUNT_W'($urandom_range(1, 15)), COUNT_W'($urandom_range(1, 15)));
        random_phase(30);
        set_limits(COUNT_W'($urandom_range(1, 15)), COUNT_W'($urandom_range(1, 15)));
        random_phase(30);

        // Top of the right limit: one unbroken turn long enough for the count to reach it,
        // then the left turn times out at once and the machine parks in stop.
        set_limits(10'd1023, 10'd1);
        run_recovery(1030, 0);
        random_phase(10);

        wait_idle();
        repeat (8) @(posedge aclk);

        $display("Covered %0d request beats and %0d result beats over %0d limit settings,",
                 beats_sent, cmds_checked, settings_used);
        $display("including %0d right-turn and %0d left-turn recovery timeouts.",
                 right_timeouts, left_timeouts);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, pending);
            $display("FAIL");
        end
        $finish;
    end

endmodule
